// ===== sv/scmr_pkg.sv =====
package scmr_pkg;

	localparam int NUM_COLUMNS   = 16384;
	localparam int COL_W         = 14;
	localparam int RATING_W      = 4;
	localparam int FRACTION_BITS = 16;
	localparam int SUM_W         = 23;
	localparam int CNT_W         = 20;
	localparam int MEAN_W        = 20;
	localparam int ROW_SUM_W     = 36;
	localparam int ROW_CNT_W     = 15;
	localparam int OUT_W         = 21;
	localparam int RESID_W       = MEAN_W + 2;

	localparam int DVD_W     = 1 + SUM_W + FRACTION_BITS;
	localparam int DVR_W     = CNT_W;
	localparam int DIV_STEPS = DVD_W;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);

	localparam logic [RATING_W-1:0]  RATING_MAX = RATING_W'(9);
	localparam logic [SUM_W-1:0]     SUM_MAX    = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0]     CNT_MAX    = {CNT_W{1'b1}};
	localparam logic [ROW_CNT_W-1:0] ROW_CNT_MAX = {ROW_CNT_W{1'b1}};
	localparam logic [DVD_W-1:0]     MEAN_MAX   = DVD_W'(9) << FRACTION_BITS;
	localparam logic [DVD_W-1:0]     OUT_POS_MAX = DVD_W'((64'd1 << (OUT_W - 1)) - 64'd1);
	localparam logic [DVD_W-1:0]     OUT_NEG_MAG = DVD_W'(64'd1 << (OUT_W - 1));

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== sv/scmr_div.sv =====
module scmr_div (
	input  logic                clk,
	input  logic                arst_n,
	input  scmr_pkg::div_req_t  req,
	output scmr_pkg::div_rsp_t  rsp
);

	logic [scmr_pkg::DVD_W-1:0]  dvd_q;
	logic [scmr_pkg::DVR_W-1:0]  dvr_q;
	logic [scmr_pkg::DVR_W-1:0]  rem_q;
	logic [scmr_pkg::STEP_W-1:0] step_q;
	logic                        done_q;
	logic [scmr_pkg::DVR_W:0]    rem_sh;
	logic [scmr_pkg::DVR_W:0]    rem_sub;
	logic                        ge;
	logic [scmr_pkg::DVR_W-1:0]  rem_nx;

	always_comb begin
		rem_sh  = {rem_q, dvd_q[scmr_pkg::DVD_W-1]};
		rem_sub = rem_sh - {1'b0, dvr_q};
		ge      = rem_sh >= {1'b0, dvr_q};
		rem_nx  = ge ? rem_sub[scmr_pkg::DVR_W-1:0] : rem_sh[scmr_pkg::DVR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == scmr_pkg::STEP_W'(1));
			if (req.start) begin
				step_q <= scmr_pkg::STEP_W'(scmr_pkg::DIV_STEPS);
			end else if (step_q != '0) begin
				step_q <= step_q - scmr_pkg::STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvr_q <= req.divisor;
			rem_q <= '0;
		end else if (step_q != '0) begin
			dvd_q <= {dvd_q[scmr_pkg::DVD_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

// ===== sv/sparse_column_mean_row_residual.sv =====
// Column means and row mean residuals over a stream of sparse rating entries.
// Input channel (in_valid/in_ready): column_index, rating, line_end, one item
// at a time. Output channel (out_valid/out_ready): average_value in signed
// Q.16 and no_observations. Config channel (cfg_valid/cfg_ready, always
// ready): pass_select, 0 for column means, 1 for row residuals; write it
// only while the block is idle.
// An item that gives no result passes through S_RD and S_UPD; then in_ready
// returns. An item that closes an empty column or row passes through S_RD,
// S_UPD and S_EMIT. An item that closes a column or row with ratings runs
// one 40-step restoring division in the shared divider, one quotient bit per
// cycle, in S_DIV between S_UPD and S_EMIT. out_valid and in_ready return as
// S_EMIT is left, which waits while an old result holds the output register.
// After reset the block sweeps all 16384 entries of the column sum/count memory
// to zero, one entry a cycle; in_ready stays low during the sweep.
// A result sits in an output register; the next item is accepted while it
// waits. If a new result is ready before the old one is taken, the block
// holds it and stays busy until out_ready frees the register.
module sparse_column_mean_row_residual (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [scmr_pkg::COL_W-1:0]         column_index,
	input  logic [scmr_pkg::RATING_W-1:0]      rating,
	input  logic                               line_end,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [scmr_pkg::OUT_W-1:0]  average_value,
	output logic                               no_observations,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               pass_select
);

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_RD   = 6'b000100,
		S_UPD  = 6'b001000,
		S_DIV  = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	localparam int CM_W = scmr_pkg::SUM_W + scmr_pkg::CNT_W;

	state_t state_q, state_nx;

	logic                              pass_q;
	logic [scmr_pkg::COL_W-1:0]        clr_q;
	logic [scmr_pkg::COL_W-1:0]        col_q;
	logic [scmr_pkg::RATING_W-1:0]     rat_q;
	logic                              last_q;
	logic                              item_pass_q;
	logic signed [scmr_pkg::ROW_SUM_W-1:0] row_sum_q;
	logic [scmr_pkg::ROW_CNT_W-1:0]    row_cnt_q;
	logic                              neg_q;
	logic [scmr_pkg::OUT_W-1:0]        res_avg_q;
	logic                              res_noobs_q;
	logic                              out_valid_q;
	logic [scmr_pkg::OUT_W-1:0]        out_avg_q;
	logic                              out_noobs_q;

	logic [CM_W-1:0]                   cm_mem [scmr_pkg::NUM_COLUMNS];
	logic [scmr_pkg::MEAN_W-1:0]       mean_mem [scmr_pkg::NUM_COLUMNS];
	logic [CM_W-1:0]                   cm_rd_q;
	logic [scmr_pkg::MEAN_W-1:0]       mean_rd_q;

	logic                              cm_we;
	logic [scmr_pkg::COL_W-1:0]        cm_wa;
	logic [CM_W-1:0]                   cm_wd;
	logic                              mean_we;
	logic [scmr_pkg::MEAN_W-1:0]       mean_wd;

	logic                              in_acc;
	logic                              emit_ok;
	logic                              valid_col;
	logic                              has_rating;
	logic [scmr_pkg::SUM_W-1:0]        sum_rd;
	logic [scmr_pkg::CNT_W-1:0]        cnt_rd;
	logic [scmr_pkg::SUM_W:0]          sum_add;
	logic [scmr_pkg::SUM_W-1:0]        sum_nx;
	logic [scmr_pkg::CNT_W-1:0]        cnt_nx;
	logic signed [scmr_pkg::RESID_W-1:0]   resid;
	logic signed [scmr_pkg::ROW_SUM_W:0]   row_add;
	logic signed [scmr_pkg::ROW_SUM_W:0]   row_lim;
	logic signed [scmr_pkg::ROW_SUM_W-1:0] row_sum_nx;
	logic [scmr_pkg::ROW_CNT_W-1:0]    row_cnt_nx;
	logic [scmr_pkg::ROW_SUM_W-1:0]    row_mag;
	logic [scmr_pkg::DVD_W-1:0]        quo;
	logic [scmr_pkg::MEAN_W-1:0]       mean_val;
	logic [scmr_pkg::OUT_W-1:0]        row_val;

	scmr_pkg::div_req_t                div_req;
	scmr_pkg::div_rsp_t                div_rsp;

	scmr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ready        = (state_q == S_IDLE);
	assign in_acc          = in_valid && in_ready;
	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign average_value   = $signed(out_avg_q);
	assign no_observations = out_noobs_q;
	assign emit_ok         = !out_valid_q || out_ready;

	assign row_lim = $signed({2'b00, {(scmr_pkg::ROW_SUM_W-1){1'b1}}});

	always_comb begin
		valid_col  = {1'b0, col_q} < (scmr_pkg::COL_W+1)'(scmr_pkg::NUM_COLUMNS);
		has_rating = valid_col && (rat_q != '0);
		sum_rd     = cm_rd_q[scmr_pkg::SUM_W-1:0];
		cnt_rd     = cm_rd_q[CM_W-1:scmr_pkg::SUM_W];
		sum_add    = {1'b0, sum_rd} + (scmr_pkg::SUM_W+1)'(rat_q);
		sum_nx     = sum_rd;
		cnt_nx     = cnt_rd;
		if (has_rating) begin
			sum_nx = (sum_add > {1'b0, scmr_pkg::SUM_MAX}) ? scmr_pkg::SUM_MAX
				: sum_add[scmr_pkg::SUM_W-1:0];
			if (cnt_rd != scmr_pkg::CNT_MAX) begin
				cnt_nx = cnt_rd + scmr_pkg::CNT_W'(1);
			end
		end

		resid = $signed({2'b00, rat_q, {scmr_pkg::FRACTION_BITS{1'b0}}})
			- $signed({2'b00, mean_rd_q});
		row_add = {row_sum_q[scmr_pkg::ROW_SUM_W-1], row_sum_q}
			+ (scmr_pkg::ROW_SUM_W+1)'(resid);
		row_sum_nx = row_sum_q;
		row_cnt_nx = row_cnt_q;
		if (has_rating) begin
			if (row_add > row_lim) begin
				row_sum_nx = row_lim[scmr_pkg::ROW_SUM_W-1:0];
			end else if (row_add < -row_lim) begin
				row_sum_nx = scmr_pkg::ROW_SUM_W'(-row_lim);
			end else begin
				row_sum_nx = row_add[scmr_pkg::ROW_SUM_W-1:0];
			end
			if (row_cnt_q != scmr_pkg::ROW_CNT_MAX) begin
				row_cnt_nx = row_cnt_q + scmr_pkg::ROW_CNT_W'(1);
			end
		end
		row_mag = row_sum_nx[scmr_pkg::ROW_SUM_W-1] ? scmr_pkg::ROW_SUM_W'(-row_sum_nx)
			: scmr_pkg::ROW_SUM_W'(row_sum_nx);

		div_req.start = 1'b0;
		if (item_pass_q) begin
			div_req.dividend = scmr_pkg::DVD_W'(row_mag)
				+ scmr_pkg::DVD_W'(row_cnt_nx[scmr_pkg::ROW_CNT_W-1:1]);
			div_req.divisor  = scmr_pkg::DVR_W'(row_cnt_nx);
		end else begin
			div_req.dividend = {1'b0, sum_nx, {scmr_pkg::FRACTION_BITS{1'b0}}}
				+ scmr_pkg::DVD_W'(cnt_nx[scmr_pkg::CNT_W-1:1]);
			div_req.divisor  = cnt_nx;
		end
		if (state_q == S_UPD && last_q) begin
			if (item_pass_q) begin
				div_req.start = (row_cnt_nx != '0);
			end else begin
				div_req.start = valid_col && (cnt_nx != '0);
			end
		end

		quo      = div_rsp.quotient;
		mean_val = (quo > scmr_pkg::MEAN_MAX) ? scmr_pkg::MEAN_MAX[scmr_pkg::MEAN_W-1:0]
			: quo[scmr_pkg::MEAN_W-1:0];
		if (!neg_q) begin
			row_val = (quo > scmr_pkg::OUT_POS_MAX) ? scmr_pkg::OUT_POS_MAX[scmr_pkg::OUT_W-1:0]
				: quo[scmr_pkg::OUT_W-1:0];
		end else begin
			row_val = (quo > scmr_pkg::OUT_NEG_MAG) ? scmr_pkg::OUT_NEG_MAG[scmr_pkg::OUT_W-1:0]
				: scmr_pkg::OUT_W'(-quo[scmr_pkg::OUT_W-1:0]);
		end

		cm_we   = 1'b0;
		cm_wa   = col_q;
		cm_wd   = {cnt_nx, sum_nx};
		mean_we = 1'b0;
		mean_wd = mean_val;
		case (state_q)
			S_CLR: begin
				cm_we = 1'b1;
				cm_wa = clr_q;
				cm_wd = '0;
			end
			S_UPD: begin
				cm_we = !item_pass_q && has_rating;
				if (!item_pass_q && valid_col && last_q && cnt_nx == '0) begin
					mean_we = 1'b1;
					mean_wd = '0;
				end
			end
			S_DIV: begin
				mean_we = div_rsp.done && !item_pass_q;
			end
			default: begin
				cm_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_CLR: begin
				if (clr_q == scmr_pkg::COL_W'(scmr_pkg::NUM_COLUMNS - 1)) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_acc) begin
					state_nx = S_RD;
				end
			end
			S_RD: begin
				state_nx = S_UPD;
			end
			S_UPD: begin
				if (div_req.start) begin
					state_nx = S_DIV;
				end else if (last_q && (item_pass_q || valid_col)) begin
					state_nx = S_EMIT;
				end else begin
					state_nx = S_IDLE;
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					state_nx = S_EMIT;
				end
			end
			S_EMIT: begin
				if (emit_ok) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			pass_q      <= 1'b0;
			row_sum_q   <= '0;
			row_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + scmr_pkg::COL_W'(1);
			end
			if (cfg_valid && cfg_ready) begin
				pass_q <= pass_select;
			end
			if (state_q == S_UPD && item_pass_q) begin
				if (last_q) begin
					row_sum_q <= '0;
					row_cnt_q <= '0;
				end else begin
					row_sum_q <= row_sum_nx;
					row_cnt_q <= row_cnt_nx;
				end
			end
			if (state_q == S_EMIT && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_q       <= column_index;
			rat_q       <= (rating > scmr_pkg::RATING_MAX) ? scmr_pkg::RATING_MAX : rating;
			last_q      <= line_end;
			item_pass_q <= pass_q;
		end
		if (state_q == S_UPD) begin
			neg_q       <= row_sum_nx[scmr_pkg::ROW_SUM_W-1];
			res_avg_q   <= '0;
			res_noobs_q <= 1'b1;
		end
		if (state_q == S_DIV && div_rsp.done) begin
			res_avg_q   <= item_pass_q ? row_val : scmr_pkg::OUT_W'(mean_val);
			res_noobs_q <= 1'b0;
		end
		if (state_q == S_EMIT && emit_ok) begin
			out_avg_q   <= res_avg_q;
			out_noobs_q <= res_noobs_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cm_we) begin
			cm_mem[cm_wa] <= cm_wd;
		end
		cm_rd_q <= cm_mem[col_q];
	end

	always_ff @(posedge clk) begin
		if (mean_we) begin
			mean_mem[col_q] <= mean_wd;
		end
		mean_rd_q <= mean_mem[col_q];
	end

endmodule
